// ----- sv/ctt_pkg.sv -----
// ----------------------------------------------------------------------------
// ctt_pkg
// Types, character codes and classification helpers shared by the
// configuration text tokenizer.
// ----------------------------------------------------------------------------
package ctt_pkg;

  localparam int unsigned CharW     = 8;
  localparam int unsigned DepthOutW = 8;
  // Width the depth is sign-extended to before taking the reported low bits.
  localparam int unsigned DepthExtW = 16;

  localparam logic [CharW-1:0] ChLbrace  = 8'h7B;
  localparam logic [CharW-1:0] ChRbrace  = 8'h7D;
  localparam logic [CharW-1:0] ChSemi    = 8'h3B;
  localparam logic [CharW-1:0] ChColon   = 8'h3A;
  localparam logic [CharW-1:0] ChSquote  = 8'h27;
  localparam logic [CharW-1:0] ChDquote  = 8'h22;
  localparam logic [CharW-1:0] ChEqual   = 8'h3D;
  localparam logic [CharW-1:0] ChComma   = 8'h2C;
  localparam logic [CharW-1:0] ChHash    = 8'h23;
  localparam logic [CharW-1:0] ChNewline = 8'h0A;
  localparam logic [CharW-1:0] ChSpace   = 8'h20;
  localparam logic [CharW-1:0] ChTab     = 8'h09;
  localparam logic [CharW-1:0] ChCr      = 8'h0D;

  typedef enum logic {
    ACT_BYTE = 1'b0,
    ACT_END  = 1'b1
  } action_e;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_PLAIN   = 3'd1,
    MODE_SQ      = 3'd2,
    MODE_DQ      = 3'd3,
    MODE_COMMENT = 3'd4
  } mode_e;

  typedef enum logic [3:0] {
    CLS_IGNORED = 4'd0,
    CLS_PLAIN   = 4'd1,
    CLS_QUOTED  = 4'd2,
    CLS_LBRACE  = 4'd3,
    CLS_RBRACE  = 4'd4,
    CLS_SEMI    = 4'd5,
    CLS_COLON   = 4'd6,
    CLS_EQUAL   = 4'd7,
    CLS_COMMA   = 4'd8,
    CLS_OQUOTE  = 4'd9,
    CLS_CQUOTE  = 4'd10
  } class_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_QUOTE    = 2'd1,
    ERR_BALANCE  = 2'd2,
    ERR_OVERFLOW = 2'd3
  } err_e;

  typedef struct packed {
    mode_e mode;
    err_e  err;
  } scan_state_t;

  typedef struct packed {
    logic [CharW-1:0]            char_out;
    class_e                      char_class;
    logic                        token_open;
    logic                        token_close;
    logic signed [DepthOutW-1:0] depth_now;
    err_e                        error_code;
    logic                        input_done;
  } result_t;

  function automatic logic is_blank(input logic [CharW-1:0] c);
    return (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
  endfunction

  // CLS_IGNORED when the byte is no punctuation token
  function automatic class_e punct_class(input logic [CharW-1:0] c);
    class_e r;
    case (c)
      ChLbrace: r = CLS_LBRACE;
      ChRbrace: r = CLS_RBRACE;
      ChSemi:   r = CLS_SEMI;
      ChColon:  r = CLS_COLON;
      ChEqual:  r = CLS_EQUAL;
      ChComma:  r = CLS_COMMA;
      default:  r = CLS_IGNORED;
    endcase
    return r;
  endfunction

  function automatic err_e keep_first(input err_e cur, input err_e code);
    return (cur == ERR_NONE) ? code : cur;
  endfunction

endpackage

// ----- sv/ctt_if.sv -----
// ----------------------------------------------------------------------------
// ctt_in_if / ctt_out_if
// Valid/ready channels for text bytes in and classified results out.
// ----------------------------------------------------------------------------
interface ctt_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] char_in;

  modport source  (output valid, action, char_in, input ready);
  modport sink    (input valid, action, char_in, output ready);
  modport monitor (input valid, ready, action, char_in);
endinterface

interface ctt_out_if;
  logic              valid;
  logic              ready;
  logic [7:0]        char_out;
  logic [3:0]        char_class;
  logic              token_open;
  logic              token_close;
  logic signed [7:0] depth_now;
  logic [1:0]        error_code;
  logic              input_done;

  modport source  (output valid, char_out, char_class, token_open, token_close,
                   depth_now, error_code, input_done, input ready);
  modport sink    (input valid, char_out, char_class, token_open, token_close,
                   depth_now, error_code, input_done, output ready);
  modport monitor (input valid, ready, char_out, char_class, token_open, token_close,
                   depth_now, error_code, input_done);
endinterface

// ----- sv/ctt_scan.sv -----
// ----------------------------------------------------------------------------
// ctt_scan
// Single-pass byte classifier: next scan state, brace depth, error latch and
// the result fields for one registered request.
// ----------------------------------------------------------------------------
module ctt_scan import ctt_pkg::*; #(
  parameter int unsigned DEPTH_BITS = 8
) (
  input  action_e                      action_i,
  input  logic [CharW-1:0]             char_i,
  input  scan_state_t                  state_i,
  input  logic signed [DEPTH_BITS-1:0] depth_i,
  output scan_state_t                  state_o,
  output logic signed [DEPTH_BITS-1:0] depth_o,
  output result_t                      res_o
);

  localparam logic signed [DEPTH_BITS-1:0] DepthMax = {1'b0, {(DEPTH_BITS-1){1'b1}}};
  localparam logic signed [DEPTH_BITS-1:0] DepthMin = {1'b1, {(DEPTH_BITS-1){1'b0}}};

  logic                        in_quote;
  logic                        in_plain;
  logic [CharW-1:0]            quote_ch;
  class_e                      pcls;
  mode_e                       mode_new;
  err_e                        err_new;
  logic signed [DEPTH_BITS-1:0] depth_new;
  logic signed [DepthExtW-1:0] depth_ext;

  assign in_quote = (state_i.mode == MODE_SQ) || (state_i.mode == MODE_DQ);
  assign in_plain = (state_i.mode == MODE_PLAIN);
  assign quote_ch = (state_i.mode == MODE_SQ) ? ChSquote : ChDquote;
  assign pcls     = punct_class(char_i);

  // Next state
  always_comb begin
    mode_new  = state_i.mode;
    err_new   = state_i.err;
    depth_new = depth_i;
    if (action_i == ACT_END) begin
      if (in_quote) begin
        err_new = keep_first(state_i.err, ERR_QUOTE);
      end else if (depth_i != '0) begin
        err_new = keep_first(state_i.err, ERR_BALANCE);
      end
    end else if (in_quote) begin
      if (char_i == ChNewline) begin
        err_new  = keep_first(state_i.err, ERR_QUOTE);
        mode_new = MODE_IDLE;
      end else if (char_i == quote_ch) begin
        mode_new = MODE_IDLE;
      end
    end else if (state_i.mode == MODE_COMMENT) begin
      if (char_i == ChNewline) begin
        mode_new = MODE_IDLE;
      end
    end else if (is_blank(char_i)) begin
      mode_new = MODE_IDLE;
    end else if (char_i == ChHash) begin
      mode_new = MODE_COMMENT;
    end else if (char_i == ChSquote) begin
      mode_new = MODE_SQ;
    end else if (char_i == ChDquote) begin
      mode_new = MODE_DQ;
    end else if (pcls != CLS_IGNORED) begin
      mode_new = MODE_IDLE;
      if (pcls == CLS_LBRACE) begin
        if (depth_i == DepthMax) begin
          err_new = keep_first(state_i.err, ERR_OVERFLOW);
        end else begin
          depth_new = depth_i + DEPTH_BITS'(1);
        end
      end else if (pcls == CLS_RBRACE) begin
        if (depth_i == DepthMin) begin
          err_new = keep_first(state_i.err, ERR_OVERFLOW);
        end else begin
          depth_new = depth_i - DEPTH_BITS'(1);
        end
      end
    end else begin
      mode_new = MODE_PLAIN;
    end
  end

  // End of input returns everything to its reset values
  always_comb begin
    if (action_i == ACT_END) begin
      state_o.mode = MODE_IDLE;
      state_o.err  = ERR_NONE;
      depth_o      = '0;
    end else begin
      state_o.mode = mode_new;
      state_o.err  = err_new;
      depth_o      = depth_new;
    end
  end

  assign depth_ext = DepthExtW'(depth_new);

  // Outputs
  always_comb begin
    res_o             = '0;
    res_o.char_out    = char_i;
    res_o.char_class  = CLS_IGNORED;
    res_o.depth_now   = depth_ext[DepthOutW-1:0];
    res_o.error_code  = err_new;
    if (action_i == ACT_END) begin
      res_o.char_out    = '0;
      res_o.input_done  = 1'b1;
      res_o.token_close = in_plain;
    end else if (in_quote) begin
      if (char_i == quote_ch) begin
        res_o.char_class  = CLS_CQUOTE;
        res_o.token_close = 1'b1;
      end else if (char_i != ChNewline) begin
        res_o.char_class  = CLS_QUOTED;
      end
    end else if (state_i.mode == MODE_COMMENT) begin
      res_o.char_class = CLS_IGNORED;
    end else if (is_blank(char_i) || (char_i == ChHash)) begin
      res_o.token_close = in_plain;
    end else if ((char_i == ChSquote) || (char_i == ChDquote)) begin
      res_o.token_close = in_plain;
      res_o.char_class  = CLS_OQUOTE;
      res_o.token_open  = 1'b1;
    end else if (pcls != CLS_IGNORED) begin
      res_o.token_close = in_plain;
      res_o.char_class  = pcls;
    end else begin
      res_o.char_class = CLS_PLAIN;
      res_o.token_open = !in_plain;
    end
  end

endmodule

// ----- sv/config_text_tokenizer_core.sv -----
// ----------------------------------------------------------------------------
// config_text_tokenizer_core
// Streaming tokenizer for configuration text, one byte per cycle while not stalled.
// ----------------------------------------------------------------------------
// Usage:
//   in_req_i  : one request per text byte (action = 0) or an end-of-input
//               marker (action = 1, byte ignored). Newline ends a line.
//   out_res_o : exactly one result per request, in request order: byte,
//               class, token open/close flags, brace depth, latched error and
//               the end-of-input flag.
// Path: a request accepted into the input register passes through the
//   classifier logic into the result register, which drives out_res_o.
// Throughput: one request per cycle sustained while out_res_o.ready holds;
//   the only loop: scan state, depth and error registers, updated per byte.
// Stall: while a result waits on out_res_o.ready, the input register still
//   takes one more request; ready drops only when both registers are full.
// Reset: scan state idle, depth zero, no error, both registers empty. An
//   end-of-input request also returns the scan state to these values, so the
//   next text starts clean.
// ----------------------------------------------------------------------------
module config_text_tokenizer_core import ctt_pkg::*; #(
  parameter int unsigned DEPTH_BITS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ctt_in_if.sink     in_req_i,
  ctt_out_if.source  out_res_o
);

  logic                         s1_valid_q;
  action_e                      s1_action_q;
  logic [CharW-1:0]             s1_char_q;
  logic                         s1_move;
  logic                         out_valid_q;
  result_t                      res_q;
  result_t                      res_d;
  scan_state_t                  state_q;
  scan_state_t                  state_d;
  logic signed [DEPTH_BITS-1:0] depth_q;
  logic signed [DEPTH_BITS-1:0] depth_d;

  assign s1_move        = s1_valid_q && (!out_valid_q || out_res_o.ready);
  assign in_req_i.ready = !s1_valid_q || s1_move;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_req_i.ready) begin
      s1_valid_q <= in_req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_req_i.ready && in_req_i.valid) begin
      s1_action_q <= action_e'(in_req_i.action);
      s1_char_q   <= in_req_i.char_in;
    end
  end

  ctt_scan #(
    .DEPTH_BITS(DEPTH_BITS)
  ) u_scan (
    .action_i(s1_action_q),
    .char_i  (s1_char_q),
    .state_i (state_q),
    .depth_i (depth_q),
    .state_o (state_d),
    .depth_o (depth_d),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode <= MODE_IDLE;
      state_q.err  <= ERR_NONE;
      depth_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (s1_move) begin
        state_q     <= state_d;
        depth_q     <= depth_d;
        out_valid_q <= 1'b1;
      end else if (out_res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      res_q <= res_d;
    end
  end

  assign out_res_o.valid       = out_valid_q;
  assign out_res_o.char_out    = res_q.char_out;
  assign out_res_o.char_class  = res_q.char_class;
  assign out_res_o.token_open  = res_q.token_open;
  assign out_res_o.token_close = res_q.token_close;
  assign out_res_o.depth_now   = res_q.depth_now;
  assign out_res_o.error_code  = res_q.error_code;
  assign out_res_o.input_done  = res_q.input_done;

endmodule

// ----- sv/ctt_checker.sv -----
// ----------------------------------------------------------------------------
// ctt_checker
// Port-level checks for the tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
module ctt_checker import ctt_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [CharW-1:0] char_out_i,
  input logic [3:0]       char_class_i,
  input logic             token_open_i,
  input logic             token_close_i,
  input logic             input_done_i
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(char_out_i) && $stable(char_class_i) &&
      $stable(token_open_i) && $stable(token_close_i) && $stable(input_done_i))
    else $error("stalled result changed");

  // A free output side always lets a new request in
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_i)
    else $error("request blocked while output is free");

  a_done_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && input_done_i |->
      char_out_i == '0 && char_class_i == CLS_IGNORED && !token_open_i)
    else $error("end-of-input result carries a byte");

  a_open_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && token_open_i |->
      char_class_i == CLS_PLAIN || char_class_i == CLS_OQUOTE)
    else $error("token open on wrong class");

  a_quote_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (char_class_i == CLS_CQUOTE) |->
      token_close_i && !token_open_i)
    else $error("closing quote without token close");

endmodule

bind config_text_tokenizer_core ctt_checker u_ctt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_i   (in_req_i.ready),
  .out_valid_i  (out_res_o.valid),
  .out_ready_i  (out_res_o.ready),
  .char_out_i   (out_res_o.char_out),
  .char_class_i (out_res_o.char_class),
  .token_open_i (out_res_o.token_open),
  .token_close_i(out_res_o.token_close),
  .input_done_i (out_res_o.input_done)
);
